// ----- design/smh_pkg.sv -----
// ---------------------------------------------------------------------------
// smh_pkg
// Shared types, constants and round functions for the SHA-256 message hasher.
// ---------------------------------------------------------------------------
package smh_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_DONE
  } state_t;

  // source of the byte shifted into the block window
  typedef enum logic [1:0] {
    SRC_IN,
    SRC_PAD,
    SRC_ZERO,
    SRC_LEN
  } src_t;

  typedef struct packed {
    logic       shift;
    src_t       src;
    logic       len_inc;
    logic       load_vars;
    logic       round_en;
    logic [5:0] round_idx;
    logic       chain_add;
    logic       digest_load;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       out_busy;
  } status_t;

  localparam logic [7:0]   PAD_BYTE   = 8'h80;
  localparam logic [5:0]   LEN_POS    = 6'd56;
  localparam logic [5:0]   LAST_POS   = 6'd63;
  localparam logic [5:0]   LAST_ROUND = 6'd63;
  localparam logic [1:0]   LAST_WORD  = 2'd3;

  localparam logic [255:0] INIT_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    round_const = k;
  endfunction

endpackage

// ----- design/smh_datapath.sv -----
// ---------------------------------------------------------------------------
// smh_datapath
// Block window, message schedule, round registers, chaining words, byte
// count and the digest output register.
// ---------------------------------------------------------------------------
module smh_datapath (
  input  logic             clk,
  input  logic             rst,
  input  smh_pkg::cmd_t    cmd,
  output smh_pkg::status_t status,
  input  logic [7:0]       data_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [63:0]      digest_word,
  output logic [1:0]       word_index,
  output logic             last_word
);

  // 64-byte window; oldest byte at the top. During rounds it rolls as the
  // schedule, word 0 holding W[i].
  logic [511:0]        win;
  logic [5:0]          fill;
  logic [60:0]         len;
  logic [0:7][31:0]    chain;
  logic [31:0]         va, vb, vc, vd, ve, vf, vg, vh;
  logic [255:0]        digest;
  logic [1:0]          idx;

  logic [7:0]          nb;
  logic [63:0]         len_bits;
  logic [31:0]         w0, w1, w9, w14, w_new;
  logic [31:0]         t1, t2;

  assign len_bits = {len, 3'b000};

  always_comb begin
    case (cmd.src)
      smh_pkg::SRC_IN:   nb = data_byte;
      smh_pkg::SRC_PAD:  nb = smh_pkg::PAD_BYTE;
      smh_pkg::SRC_LEN:  nb = 8'(len_bits >> (6'd56 - {fill[2:0], 3'b000}));
      default:           nb = 8'h00;
    endcase
  end

  assign w0    = win[511:480];
  assign w1    = win[479:448];
  assign w9    = win[223:192];
  assign w14   = win[63:32];
  assign w_new = smh_pkg::small_sigma1(w14) + w9 + smh_pkg::small_sigma0(w1) + w0;

  assign t1 = vh + smh_pkg::big_sigma1(ve) + ((ve & vf) ^ (~ve & vg))
            + smh_pkg::round_const(cmd.round_idx) + w0;
  assign t2 = smh_pkg::big_sigma0(va) + ((va & vb) ^ (va & vc) ^ (vb & vc));

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      win <= {win[503:0], nb};
    end else if (cmd.round_en) begin
      win <= {win[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      len  <= '0;
    end else begin
      if (cmd.shift) begin
        fill <= fill + 6'd1;
      end
      if (cmd.digest_load) begin
        len <= '0;
      end else if (cmd.len_inc) begin
        len <= len + 61'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= smh_pkg::INIT_HASH;
    end else if (cmd.digest_load) begin
      chain <= smh_pkg::INIT_HASH;
    end else if (cmd.chain_add) begin
      chain[0] <= chain[0] + va;
      chain[1] <= chain[1] + vb;
      chain[2] <= chain[2] + vc;
      chain[3] <= chain[3] + vd;
      chain[4] <= chain[4] + ve;
      chain[5] <= chain[5] + vf;
      chain[6] <= chain[6] + vg;
      chain[7] <= chain[7] + vh;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_vars) begin
      {va, vb, vc, vd, ve, vf, vg, vh} <= chain;
    end else if (cmd.round_en) begin
      vh <= vg;
      vg <= vf;
      vf <= ve;
      ve <= vd + t1;
      vd <= vc;
      vc <= vb;
      vb <= va;
      va <= t1 + t2;
    end
  end

  // digest register lets the next message run while the words drain
  always_ff @(posedge clk) begin
    if (cmd.digest_load) begin
      digest <= chain;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (cmd.digest_load) begin
      out_valid <= 1'b1;
      idx       <= '0;
    end else if (out_valid && !out_stall) begin
      idx <= idx + 2'd1;
      if (idx == smh_pkg::LAST_WORD) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign digest_word = 64'(digest >> {~idx, 6'b000000});
  assign word_index  = idx;
  assign last_word   = (idx == smh_pkg::LAST_WORD);

  assign status.fill     = fill;
  assign status.out_busy = out_valid;

endmodule

// ----- design/smh_ctrl.sv -----
// ---------------------------------------------------------------------------
// smh_ctrl
// Sequencer: byte intake, padding, round count and digest hand-off.
// ---------------------------------------------------------------------------
module smh_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             carries_byte,
  input  logic             last_byte,
  input  smh_pkg::status_t status,
  output smh_pkg::cmd_t    cmd
);

  smh_pkg::state_t state, state_next;
  logic [5:0]      rnd, rnd_next;
  logic            pend, pend_next;     // message closed, padding not yet done
  logic            pfirst, pfirst_next; // next pad byte is the 0x80 marker
  logic            ovf, ovf_next;       // length does not fit this block
  logic            fin, fin_next;       // block in flight carries the length

  logic            full;
  logic            in_len_field;
  logic            ovf_eff;

  assign full         = (status.fill == smh_pkg::LAST_POS);
  assign in_len_field = (status.fill >= smh_pkg::LEN_POS);
  assign ovf_eff      = ovf | (pfirst & in_len_field);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= smh_pkg::ST_IDLE;
      rnd    <= '0;
      pend   <= 1'b0;
      pfirst <= 1'b0;
      ovf    <= 1'b0;
      fin    <= 1'b0;
    end else begin
      state  <= state_next;
      rnd    <= rnd_next;
      pend   <= pend_next;
      pfirst <= pfirst_next;
      ovf    <= ovf_next;
      fin    <= fin_next;
    end
  end

  always_comb begin
    state_next  = state;
    rnd_next    = rnd;
    pend_next   = pend;
    pfirst_next = pfirst;
    ovf_next    = ovf;
    fin_next    = fin;
    case (state)
      smh_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (carries_byte && full) begin
            state_next  = smh_pkg::ST_ROUND;
            pend_next   = last_byte;
            pfirst_next = last_byte;
          end else if (last_byte) begin
            state_next  = smh_pkg::ST_PAD;
            pend_next   = 1'b1;
            pfirst_next = 1'b1;
          end
        end
      end
      smh_pkg::ST_ROUND: begin
        rnd_next = rnd + 6'd1;
        if (rnd == smh_pkg::LAST_ROUND) begin
          state_next = smh_pkg::ST_ADD;
        end
      end
      smh_pkg::ST_ADD: begin
        if (fin) begin
          state_next = smh_pkg::ST_DONE;
        end else if (pend) begin
          state_next = smh_pkg::ST_PAD;
        end else begin
          state_next = smh_pkg::ST_IDLE;
        end
      end
      smh_pkg::ST_PAD: begin
        pfirst_next = 1'b0;
        if (full) begin
          state_next = smh_pkg::ST_ROUND;
          fin_next   = ~ovf_eff;
          ovf_next   = 1'b0;
        end else begin
          ovf_next = ovf_eff;
        end
      end
      smh_pkg::ST_DONE: begin
        if (!status.out_busy) begin
          state_next = smh_pkg::ST_IDLE;
          pend_next  = 1'b0;
          fin_next   = 1'b0;
        end
      end
      default: begin
        state_next = smh_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.src       = smh_pkg::SRC_IN;
    cmd.round_idx = rnd;
    in_stall      = (state != smh_pkg::ST_IDLE);
    case (state)
      smh_pkg::ST_IDLE: begin
        if (in_valid && carries_byte) begin
          cmd.shift     = 1'b1;
          cmd.len_inc   = 1'b1;
          cmd.load_vars = full;
        end
      end
      smh_pkg::ST_ROUND: begin
        cmd.round_en = 1'b1;
      end
      smh_pkg::ST_ADD: begin
        cmd.chain_add = 1'b1;
      end
      smh_pkg::ST_PAD: begin
        cmd.shift     = 1'b1;
        cmd.load_vars = full;
        if (pfirst) begin
          cmd.src = smh_pkg::SRC_PAD;
        end else if (in_len_field && !ovf) begin
          cmd.src = smh_pkg::SRC_LEN;
        end else begin
          cmd.src = smh_pkg::SRC_ZERO;
        end
      end
      smh_pkg::ST_DONE: begin
        cmd.digest_load = ~status.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- design/sha256_message_hasher.sv -----
// ---------------------------------------------------------------------------
// sha256_message_hasher
// Streaming SHA-256: one message byte per item in, four 64-bit digest words
// out per message, most significant word first.
// ---------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_stall | data_byte, carries_byte, last_byte
//  out     | out_valid/out_stall | digest_word, word_index, last_word
//
//  A byte item is taken while the sequencer idles; the item completing a 64-byte
//  block adds the compression rounds and one chaining add.
//  A last item adds byte-serial padding to the block end (and an extra block
//  when the length spills into it), then the rounds for each padded block.
//  A done state loads the digest; input is held there until earlier words drain.
//  Synchronous reset loads the initial hash values and clears the byte count.
// ---------------------------------------------------------------------------
module sha256_message_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        carries_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word
);

  smh_pkg::cmd_t    cmd;
  smh_pkg::status_t status;

  smh_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .carries_byte (carries_byte),
    .last_byte    (last_byte),
    .status       (status),
    .cmd          (cmd)
  );

  smh_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

`ifndef NO_ASSERTIONS
  // a new digest never overwrites words still draining
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.digest_load |-> !out_valid)
    else $error("digest loaded while output busy");

  // compression only starts on the byte that fills the block
  a_full_block: assert property (@(posedge clk) disable iff (rst)
    cmd.load_vars |-> (cmd.shift && status.fill == smh_pkg::LAST_POS))
    else $error("compression started on a partial block");

  // words leave in order once taken
  a_word_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_word) |=>
      (out_valid && word_index == $past(word_index) + 2'd1))
    else $error("digest word order broken");

  // no byte is taken while a block is being compressed
  a_no_intake: assert property (@(posedge clk) disable iff (rst)
    cmd.round_en |-> in_stall)
    else $error("input accepted during rounds");
`endif

endmodule

// ----- tb/sv/sha256_message_hasher_tb.sv -----
// ---------------------------------------------------------------------------
// sha256_message_hasher_tb
// Byte items go into the hasher with random gaps and a long receiver hold-off.
// A bit-true SHA-256 model predicts the four digest words of every message.
// Each word that comes out is checked against the oldest prediction.
// ---------------------------------------------------------------------------
module sha256_message_hasher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 1200;
  localparam int DRAIN_CYCLES = 300;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_ITEMS = 155;

  localparam bit [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam bit [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [63:0] word;
    logic [1:0]  index;
    logic        last;
  } digest_part_t;

  class digest_ledger;
    bit [31:0]    chain [8];
    bit [7:0]     block [64];
    bit [60:0]    msg_len;
    digest_part_t digests_due [$];
    int           mismatches;

    function new();
      mismatches = 0;
      restart_message();
    endfunction

    function void restart_message();
      chain = SHA_IV;
      msg_len = '0;
    endfunction

    function bit [31:0] rot_right(bit [31:0] x, int n);
      bit [63:0] doubled;
      doubled = {x, x} >> n;
      return doubled[31:0];
    endfunction

    function void compress();
      bit [31:0] w [16];
      bit [31:0] v [8];
      bit [31:0] t1, t2, x15, x2;
      int i;
      for (i = 0; i < 16; i++) begin
        w[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
      end
      v = chain;
      for (i = 0; i < 64; i++) begin
        // schedule kept as a rolling window of sixteen words
        if (i >= 16) begin
          x15 = w[(i - 15) % 16];
          x2 = w[(i - 2) % 16];
          w[i % 16] = w[i % 16] + w[(i - 7) % 16]
                    + (rot_right(x15, 7) ^ rot_right(x15, 18) ^ (x15 >> 3))
                    + (rot_right(x2, 17) ^ rot_right(x2, 19) ^ (x2 >> 10));
        end
        t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i % 16];
        t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    function void absorb_item(bit [7:0] data, bit carries, bit ends);
      int pos, k;
      bit [63:0] bit_len;
      digest_part_t part;
      if (carries) begin
        pos = int'(msg_len[5:0]);
        block[pos] = data;
        msg_len = msg_len + 1'b1;
        if (pos == 63) compress();
      end
      if (ends) begin
        pos = int'(msg_len[5:0]);
        block[pos] = smh_pkg::PAD_BYTE;
        for (k = pos + 1; k < 64; k++) block[k] = 8'h00;
        // length field no longer fits: flush and pad a second block
        if (pos >= int'(smh_pkg::LEN_POS)) begin
          compress();
          for (k = 0; k < 64; k++) block[k] = 8'h00;
        end
        bit_len = {msg_len, 3'b000};
        for (k = 0; k < 8; k++) block[56 + k] = bit_len[63 - 8*k -: 8];
        compress();
        for (k = 0; k < 4; k++) begin
          part.word = {chain[2*k], chain[2*k + 1]};
          part.index = 2'(k);
          part.last = (2'(k) == smh_pkg::LAST_WORD);
          digests_due.push_back(part);
        end
        restart_message();
      end
    endfunction

    function void check_word(logic [63:0] word, logic [1:0] index, logic last);
      digest_part_t want;
      if (digests_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected digest word %h index %0d last %0b",
                   $time, word, index, last);
        return;
      end
      want = digests_due.pop_front();
      if (word !== want.word || index !== want.index || last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] digest word: expected %h/%0d/%0b, got %h/%0d/%0b", $time,
                   want.word, want.index, want.last, word, index, last);
      end
    endfunction

    function int outstanding();
      return digests_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        carries_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  logic         hold_off;
  bit           calm;
  int           words_checked;
  digest_ledger ledger;

  sha256_message_hasher dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .carries_byte (carries_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one item: random gap, then hold it until the block takes it
  task automatic offer(input logic [7:0] data, input logic carries, input logic ends);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= data;
    carries_byte <= carries;
    last_byte <= ends;
    do @(posedge clk); while (in_stall);
    ledger.absorb_item(data, carries, ends);
  endtask

  // random bytes, with occasional idle items; closed on the final byte or by a separate empty item
  task automatic send_message(input int n_bytes, output int n_items);
    int i;
    bit split_close;
    split_close = (n_bytes == 0) || ($urandom_range(1) == 1);
    n_items = 0;
    for (i = 0; i < n_bytes; i++) begin
      if ($urandom_range(99) < 5) offer(8'($urandom_range(255)), 1'b0, 1'b0);
      offer(8'($urandom_range(255)), 1'b1, !split_close && i == n_bytes - 1);
      n_items++;
    end
    if (split_close) begin
      offer(8'($urandom_range(255)), 1'b0, 1'b1);
      n_items++;
    end
  endtask

  initial begin
    int sent, got, len;
    ledger = new();
    calm = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    data_byte <= 8'h00;
    carries_byte <= 1'b0;
    last_byte <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty message straight after reset, byte field ignored; then idle items and two one-byte messages
    offer(8'hff, 1'b0, 1'b1);
    offer(8'h00, 1'b0, 1'b0);
    offer(8'ha5, 1'b0, 1'b0);
    offer(8'h00, 1'b1, 1'b1);
    offer(8'hff, 1'b1, 1'b1);
    // "abc" with an idle item inside and an empty close, then a two-byte message and two empty ones
    offer(8'h61, 1'b1, 1'b0);
    offer(8'h5a, 1'b0, 1'b0);
    offer(8'h62, 1'b1, 1'b0);
    offer(8'h63, 1'b1, 1'b0);
    offer(8'h00, 1'b0, 1'b1);
    offer(8'h55, 1'b1, 1'b0);
    offer(8'haa, 1'b1, 1'b1);
    offer(8'h00, 1'b0, 1'b1);
    offer(8'hff, 1'b0, 1'b1);

    // length spills into an extra block, then an exactly full block, then random lengths
    sent = 0;
    send_message(56, got);
    sent += got;
    send_message(64, got);
    sent += got;
    while (sent < RANDOM_ITEMS) begin
      calm = (sent >= 120 && sent < 150);
      if ($urandom_range(99) < 85) begin
        len = $urandom_range(12);
      end else begin
        case ($urandom_range(2))
          0: len = 55;
          1: len = 57;
          default: len = 63;
        endcase
      end
      send_message(len, got);
      sent += got;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
      $display("sha256_message_hasher verification clean");
    end else begin
      $display("sha256_message_hasher verification failed");
    end
    $finish;
  end

  initial begin
    out_stall <= 1'b0;
    words_checked = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall) begin
        ledger.check_word(digest_word, word_index, last_word);
        words_checked++;
      end
      out_stall <= hold_off || (!calm && $urandom_range(99) < 36);
    end
  end

  // long receiver hold-off once the directed messages are through
  initial begin
    int held;
    hold_off <= 1'b0;
    do @(posedge clk); while (words_checked < 28);
    hold_off <= 1'b1;
    for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sha256_message_hasher verification failed");
    $finish;
  end

endmodule
